FILE: rtl/lrup_pkg.sv
// lrup_pkg: shared constants and types for the lru page replacement block
// no dependencies; used by lrup_cell, lrup_stack and lru_page_replacement
package lrup_pkg;

  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 32;

  localparam int FIELD_W = 32;   // width of page and count fields on the ports
  localparam int CAP_W   = 4;    // capacity register width
  localparam int ADDR_W  = 3;    // byte address, one 32-bit register
  localparam int DATA_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(3);

  // register index, taken from the word address bits of paddr
  localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;

  typedef struct packed {
    logic upd;    // a word is accepted this cycle
    logic hit;    // the page sits in some valid cell
    logic evict;  // miss with the store full: last valid cell drops out
    logic trim;   // capacity write: drop cells at or beyond the new capacity
  } lrup_ctrl_t;

endpackage

FILE: rtl/lru_page_replacement.sv
// lru_page_replacement: fully associative lru page store on a chain of cells.
// a result word is registered at the end of the cycle in which its page word is accepted.
// throughput: one word per cycle while the receiver keeps up; the compare and shift across the cell row
// completes in the accepting cycle, and the output register decouples the sides.
// reset (synchronous, active low): all cells empty, occupancy and fault count zero,
// capacity 3. depends on lrup_pkg, lrup_stack, lrup_cell
module lru_page_replacement #(
  parameter int FRAMES    = lrup_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lrup_pkg::PAGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lrup_pkg::FIELD_W-1:0] in_page,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_fault,
  output logic                        out_evicted_valid,
  output logic [lrup_pkg::FIELD_W-1:0] out_evicted_page,
  output logic [lrup_pkg::FIELD_W-1:0] out_fault_total,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrup_pkg::ADDR_W-1:0]  paddr,
  input  logic [lrup_pkg::DATA_W-1:0]  pwdata,
  output logic [lrup_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import lrup_pkg::*;

  localparam int OCC_W = $clog2(FRAMES + 1);
  localparam int EW    = (CAP_W > OCC_W) ? CAP_W + 1 : OCC_W + 1;

  logic [CAP_W-1:0]     cap_r, cap_nxt;
  logic [OCC_W-1:0]     occ_r, occ_nxt;
  logic [FIELD_W-1:0]   cnt_r, cnt_nxt;
  logic [CAP_W-1:0]     cap_src;
  logic [OCC_W-1:0]     cap_eff;
  logic                 cfg_wr;
  logic                 accept;
  logic [PAGE_BITS-1:0] pg;
  logic                 hit;
  logic [PAGE_BITS-1:0] lru_page;
  logic [FRAMES-1:0]    valid_vec;
  lrup_ctrl_t           ctrl;

  logic                 out_valid_r, out_valid_nxt;
  logic                 fault_r, ev_valid_r;
  logic [FIELD_W-1:0]   ev_page_r, total_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[ADDR_W-1:2] == REG_CAPACITY);
  assign prdata = (paddr[ADDR_W-1:2] == REG_CAPACITY) ? DATA_W'(cap_r) : '0;

  // capacity in effect: the new value during a write, clamped to 1..FRAMES
  assign cap_src = cfg_wr ? pwdata[CAP_W-1:0] : cap_r;
  always_comb begin
    priority if (cap_src == '0) begin
      cap_eff = OCC_W'(1);
    end else if (EW'(cap_src) > EW'(FRAMES)) begin
      cap_eff = OCC_W'(FRAMES);
    end else begin
      cap_eff = OCC_W'(cap_src);
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign pg       = PAGE_BITS'(in_page);

  assign ctrl.upd   = accept;
  assign ctrl.hit   = hit;
  assign ctrl.evict = !hit && (occ_r >= cap_eff);
  assign ctrl.trim  = cfg_wr;

  lrup_stack #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .OCC_W     (OCC_W)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .cap_eff   (cap_eff),
    .pg        (pg),
    .hit       (hit),
    .lru_page  (lru_page),
    .valid_vec (valid_vec)
  );

  always_comb begin
    cap_nxt = cap_r;
    occ_nxt = occ_r;
    cnt_nxt = cnt_r;
    priority if (cfg_wr) begin
      cap_nxt = pwdata[CAP_W-1:0];
      if (occ_r > cap_eff) begin
        occ_nxt = cap_eff;
      end
    end else if (accept && !hit) begin
      if (cnt_r != '1) begin
        cnt_nxt = cnt_r + FIELD_W'(1);
      end
      if (!ctrl.evict) begin
        occ_nxt = occ_r + OCC_W'(1);
      end
    end else begin
      occ_nxt = occ_r;
      cnt_nxt = cnt_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fault_r    <= !hit;
      ev_valid_r <= ctrl.evict;
      ev_page_r  <= ctrl.evict ? FIELD_W'(lru_page) : '0;
      total_r    <= cnt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fault         = fault_r;
  assign out_evicted_valid = ev_valid_r;
  assign out_evicted_page  = ev_page_r;
  assign out_fault_total   = total_r;

  // occupancy counter tracks the cell valid bits
  a_occ_count : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(occ_r))
    else $error("occupancy does not match valid cells");

  // valid cells stay packed at the most recent end
  a_packed : assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + FRAMES'(1)) & valid_vec) == '0)
    else $error("valid cells not contiguous");

  a_occ_cap : assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr |-> (occ_r <= cap_eff))
    else $error("occupancy above capacity");

  // an eviction only ever comes with a fault
  a_evict_fault : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!ev_valid_r || fault_r))
    else $error("eviction reported on a hit");

endmodule

FILE: rtl/lrup_cell.sv
// lrup_cell: one position of the recency stack, holding a page and its valid bit
// depends on lrup_pkg; instantiated in a row by lrup_stack
module lrup_cell #(
  parameter int IDX       = 0,
  parameter int PAGE_BITS = 32,
  parameter int OCC_W     = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lrup_pkg::lrup_ctrl_t  ctrl,
  input  logic [OCC_W-1:0]      cap_eff,
  input  logic [PAGE_BITS-1:0]  pg,
  input  logic [PAGE_BITS-1:0]  up_page,
  input  logic                  up_valid,
  input  logic                  up_clear,
  output logic [PAGE_BITS-1:0]  page_q,
  output logic                  valid_q,
  output logic                  clear_out
);
  import lrup_pkg::*;

  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 valid_r, valid_nxt;
  logic                 match;
  logic                 shift;

  assign match     = valid_r && (page_r == pg);
  // no match seen in this cell or any more recent one
  assign clear_out = up_clear && !match;

  always_comb begin
    priority if (ctrl.hit) begin
      shift = up_clear;
    end else if (ctrl.evict) begin
      shift = valid_r;
    end else begin
      shift = up_valid;
    end
  end

  always_comb begin
    page_nxt  = page_r;
    valid_nxt = valid_r;
    priority if (ctrl.trim) begin
      valid_nxt = valid_r && (OCC_W'(IDX) < cap_eff);
    end else if (ctrl.upd) begin
      if (shift) begin
        page_nxt = up_page;
      end
      if (!ctrl.hit && !ctrl.evict) begin
        valid_nxt = valid_r || up_valid;
      end
    end else begin
      page_nxt  = page_r;
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign page_q  = page_r;
  assign valid_q = valid_r;

endmodule

FILE: rtl/lrup_stack.sv
// lrup_stack: row of lrup_cell instances forming the recency stack, with hit and
// lru page selection; depends on lrup_pkg and lrup_cell
module lrup_stack #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 32,
  parameter int OCC_W     = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lrup_pkg::lrup_ctrl_t  ctrl,
  input  logic [OCC_W-1:0]      cap_eff,
  input  logic [PAGE_BITS-1:0]  pg,
  output logic                  hit,
  output logic [PAGE_BITS-1:0]  lru_page,
  output logic [FRAMES-1:0]     valid_vec
);
  import lrup_pkg::*;

  logic [PAGE_BITS-1:0] page_q [FRAMES];
  logic [PAGE_BITS-1:0] up_page [FRAMES];
  logic [FRAMES-1:0]    up_valid;
  logic [FRAMES:0]      clear_chain;
  logic [FRAMES-1:0]    last_vec;

  assign clear_chain[0] = 1'b1;

  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign up_page[k]  = pg;
      assign up_valid[k] = 1'b1;
    end else begin : g_body
      assign up_page[k]  = page_q[k-1];
      assign up_valid[k] = valid_vec[k-1];
    end

    lrup_cell #(
      .IDX       (k),
      .PAGE_BITS (PAGE_BITS),
      .OCC_W     (OCC_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .cap_eff   (cap_eff),
      .pg        (pg),
      .up_page   (up_page[k]),
      .up_valid  (up_valid[k]),
      .up_clear  (clear_chain[k]),
      .page_q    (page_q[k]),
      .valid_q   (valid_vec[k]),
      .clear_out (clear_chain[k+1])
    );
  end

  assign hit = !clear_chain[FRAMES];

  // valid cells are contiguous from the top, so the last one is the lru page
  assign last_vec = valid_vec & ~(valid_vec >> 1);

  always_comb begin
    lru_page = '0;
    for (int k = 0; k < FRAMES; k++) begin
      lru_page = lru_page | (page_q[k] & {PAGE_BITS{last_vec[k]}});
    end
  end

endmodule

FILE: tb/tb_lru_page_replacement.sv
// tb_lru_page_replacement: self-checking bench for the lru page store, with its own
// recency-stack predictor, a queue-fed driver, a result monitor and apb capacity writes
// depends on lrup_pkg and lru_page_replacement
module tb_lru_page_replacement;

  localparam int FRAMES      = lrup_pkg::FRAMES_DEF;
  localparam int FW          = lrup_pkg::FIELD_W;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 75;

  localparam logic [lrup_pkg::ADDR_W-3:0] REG_UNUSED = 1'b1;

  typedef struct packed {
    logic          fault;
    logic          evicted_valid;
    logic [FW-1:0] evicted_page;
    logic [FW-1:0] fault_total;
  } page_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [FW-1:0]               in_page = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        out_fault;
  logic                        out_evicted_valid;
  logic [FW-1:0]               out_evicted_page;
  logic [FW-1:0]               out_fault_total;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [lrup_pkg::ADDR_W-1:0] paddr = '0;
  logic [lrup_pkg::DATA_W-1:0] pwdata = '0;
  logic [lrup_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  lru_page_replacement dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_page(in_page),
    .out_valid(out_valid), .out_ready(out_ready), .out_fault(out_fault),
    .out_evicted_valid(out_evicted_valid), .out_evicted_page(out_evicted_page),
    .out_fault_total(out_fault_total),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predicted store contents, position 0 is the most recent page
  logic [FW-1:0]          stack_page [FRAMES] = '{default: '0};
  int                     stack_used = 0;
  logic [FW-1:0]          fault_count = '0;
  logic [lrup_pkg::CAP_W-1:0] capacity_reg = lrup_pkg::CAP_RESET;

  logic [FW-1:0] pending_pages [$];
  page_result_t  expected_results [$];
  int            err_count = 0;
  int            cycle_count = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            hold_left = 0;

  function automatic int eff_capacity();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > FRAMES) return FRAMES;
    return int'(capacity_reg);
  endfunction

  function automatic void trim_stack();
    if (stack_used > eff_capacity()) stack_used = eff_capacity();
  endfunction

  function automatic void shift_in(int upto, logic [FW-1:0] pg);
    for (int k = upto; k > 0; k--) begin
      if (k < FRAMES) stack_page[k] = stack_page[k-1];
    end
    stack_page[0] = pg;
  endfunction

  function automatic page_result_t lru_access(logic [FW-1:0] pg);
    page_result_t r;
    int hit_at;
    r = '0;
    hit_at = -1;
    for (int k = 0; k < stack_used; k++) begin
      if (hit_at < 0 && stack_page[k] == pg) hit_at = k;
    end
    if (hit_at >= 0) begin
      shift_in(hit_at, pg);
    end else begin
      r.fault = 1'b1;
      if (fault_count != '1) fault_count++;
      if (stack_used >= eff_capacity() && stack_used > 0) begin
        r.evicted_valid = 1'b1;
        r.evicted_page  = stack_page[stack_used-1];
        shift_in(stack_used - 1, pg);
      end else begin
        shift_in(stack_used, pg);
        if (stack_used < FRAMES) stack_used++;
      end
      trim_stack();
    end
    r.fault_total = fault_count;
    return r;
  endfunction

  // append helpers for the pending and expected queues
  function automatic void queue_page(logic [FW-1:0] pg);
    pending_pages.insert(pending_pages.size(), pg);
  endfunction

  function automatic void add_expected(page_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  task automatic check_field(string name, logic [FW-1:0] exp_v, logic [FW-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t mismatch %s: expected %h got %h", $time, name, exp_v, got_v);
      err_count++;
    end
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  // driver: a new word goes out only when the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) add_expected(lru_access(in_page));
      if (!in_valid || in_ready) begin
        if (pending_pages.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_page  <= pending_pages.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    page_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result word: fault %b evicted %b/%h total %h", $time,
                 out_fault, out_evicted_valid, out_evicted_page, out_fault_total);
        err_count++;
      end else begin
        e = expected_results.pop_front();
        check_field("fault", FW'(e.fault), FW'(out_fault));
        check_field("evicted_valid", FW'(e.evicted_valid), FW'(out_evicted_valid));
        check_field("evicted_page", e.evicted_page, out_evicted_page);
        check_field("fault_total", e.fault_total, out_fault_total);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [lrup_pkg::ADDR_W-3:0] idx, logic [lrup_pkg::DATA_W-1:0] d);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == lrup_pkg::REG_CAPACITY) begin
      capacity_reg = d[lrup_pkg::CAP_W-1:0];
      trim_stack();
    end
  endtask

  task automatic check_capacity_readback();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {lrup_pkg::REG_CAPACITY, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("capacity readback", FW'(capacity_reg), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // sampled at the falling edge so the driver's update of this edge is visible
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_pages.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // mostly a small working set, half of it near-identical pages, so hits and evictions both occur
  task automatic queue_random(int n);
    logic [FW-1:0] ws [12];
    logic [FW-1:0] base;
    base = $urandom();
    foreach (ws[k]) ws[k] = (k < 6) ? base ^ (32'h1 << $urandom_range(31)) : $urandom();
    ws[0] = base;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 85) queue_page(ws[$urandom_range(11)]);
      else queue_page($urandom());
    end
  endtask

  initial begin
    int phase_cap [4];
    int idle_tab [4];
    int stall_tab [4];
    phase_cap = '{1, 8, 15, 0};
    idle_tab  = '{0, 67, 0, 25};
    stall_tab = '{0, 0, 67, 25};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    check_capacity_readback();

    // reset capacity of three: extremes, hits at every depth, an eviction
    queue_page(32'h0000_0000);
    queue_page(32'hFFFF_FFFF);
    queue_page(32'h0000_0000);
    queue_page(32'h0000_0005);
    queue_page(32'h0000_0007);
    queue_page(32'h0000_0000);
    queue_page(32'h0000_0007);
    queue_page(32'h0000_0007);
    wait_idle();

    // upper data bits are ignored by the capacity register
    write_reg(lrup_pkg::REG_CAPACITY, 32'hFFFF_FFF1);
    check_capacity_readback();
    queue_page(32'h0000_0001);
    queue_page(32'h0000_0001);
    queue_page(32'h0000_0002);
    wait_idle();

    // zero capacity behaves as one
    write_reg(lrup_pkg::REG_CAPACITY, 32'h0);
    queue_page(32'h0000_0003);
    queue_page(32'h0000_0003);
    wait_idle();

    write_reg(lrup_pkg::REG_CAPACITY, 32'h8);
    for (int k = 0; k < FRAMES; k++) queue_page(32'h1000_0000 + k);
    queue_page(32'h1000_0008);
    queue_page(32'h1000_0001);
    wait_idle();

    // capacity above the built depth clamps to it
    write_reg(lrup_pkg::REG_CAPACITY, 32'hF);
    queue_page(32'h1000_0009);
    wait_idle();

    // shrinking drops the oldest frames without reporting them
    write_reg(lrup_pkg::REG_CAPACITY, 32'h2);
    queue_page(32'h1000_0003);
    wait_idle();

    // a write to an unmapped register leaves capacity alone
    write_reg(REG_UNUSED, 32'h0000_0007);
    check_capacity_readback();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(lrup_pkg::REG_CAPACITY, (ph < 4) ? phase_cap[ph] : $urandom_range(15));
      send_idle_pct  = idle_tab[ph % 4];
      recv_stall_pct = stall_tab[ph % 4];
      queue_random(PHASE_ITEMS);
      if (ph == 4) begin
        @(negedge clk);
        hold_left = 300;
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
